// ===== sv/mre_pkg.sv =====
// mre_pkg: shared sizes, command and status codes, and the record types
// passed between the table memory, the scan unit and the top level.
// No dependencies.
package mre_pkg;

    // table geometry and field widths
    localparam int ENTRIES    = 1024;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = 20;
    localparam int KEY_W      = 32;
    localparam int RANK_W     = 20;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int OUT_DATA_W = ((RANK_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] CNT_MAX  = '1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RANK   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] RES_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] RES_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] RES_ABSENT = 2'd2;

    // one table entry: key and copy count, count of zero marks it free
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    // table write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    // scan unit control
    typedef struct packed {
        logic             start;
        logic             valid;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    // scan unit result
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] hit_idx;
        logic [CNT_W-1:0] hit_cnt;
        logic             have_free;
        logic [IDX_W-1:0] free_idx;
        logic [CNT_W-1:0] smaller;
    } scan_res_t;

endpackage

// ===== sv/mre_table.sv =====
// mre_table: key and count table, one write port and one read port with
// registered read data. Depends on mre_pkg.
module mre_table
    import mre_pkg::*;
(
    input  logic             aclk,
    input  tbl_wr_t          wr,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data_reg
);

    entry_t mem [ENTRIES];

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// ===== sv/mre_scan.sv =====
// mre_scan: shared compare and accumulate unit, takes one table entry per
// cycle while ctl.valid is high and tracks the key match, the first free
// entry and the smaller sum. Depends on mre_pkg.
module mre_scan
    import mre_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  scan_ctl_t        ctl,
    input  logic [KEY_W-1:0] key,
    input  entry_t           entry,
    output scan_res_t        res_reg
);

    scan_res_t res_next;

    // start clears the result; else one valid entry per cycle: free, match, or smaller key
    always_comb begin
        res_next = res_reg;
        if (ctl.start) begin
            res_next = '0;
        end else if (ctl.valid) begin
            if (entry.cnt == '0) begin
                if (!res_reg.have_free) begin
                    res_next.have_free = 1'b1;
                    res_next.free_idx  = ctl.idx;
                end
            end else if (entry.key == key) begin
                res_next.found   = 1'b1;
                res_next.hit_idx = ctl.idx;
                res_next.hit_cnt = entry.cnt;
            end else if ($signed(entry.key) < $signed(key)) begin
                res_next.smaller = res_reg.smaller + entry.cnt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== sv/multiset_rank_engine_core.sv =====
// Multiset rank engine: keeps a multiset of signed 32-bit keys with duplicate
// counts in a 1024-entry table. Each input transfer carries a command in
// s_tuser (insert, delete one copy, rank) and the key in s_tdata, and gives
// exactly one result transfer: rank in m_tdata, status in m_tuser. After
// reset a clearing sweep writes every table entry free, one per cycle, while
// s_tready stays low. Each command then steps from acceptance through the
// scan state, where the table (one write port, one registered read port) is
// read one entry per cycle and every entry is scanned once, a drain state for
// the read pipeline, a write-back state that issues the result, and the idle
// state with s_tready high. A finished result waits in an output register;
// while an earlier result is still held there, the write-back step waits and
// adds that wait to the command.
// Depends on mre_pkg, mre_table and mre_scan.
module multiset_rank_engine_core
    import mre_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [KEY_W-1:0]      s_tdata,   // key[31:0]
    input  logic [CMD_W-1:0]      s_tuser,   // cmd[1:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // rank[19:0], zero fill
    output logic [STATUS_W-1:0]   m_tuser    // status[1:0]
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    tbl_wr_t              wr;
    entry_t               rd_data;
    scan_ctl_t            scan_ctl;
    scan_res_t            scan_res;

    logic                 in_xfer;
    logic                 out_free;
    logic                 upd_en;
    logic [IDX_W-1:0]     upd_addr;
    logic [CNT_W-1:0]     upd_cnt;
    logic [CNT_W-1:0]     upd_total;
    logic [STATUS_W-1:0]  status_calc;
    logic [RANK_W-1:0]    rank_calc;
    logic [CNT_W-1:0]     rank_sum;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // table and scan unit
    mre_table u_table (
        .aclk        (aclk),
        .wr          (wr),
        .rd_addr     (idx_reg),
        .rd_data_reg (rd_data)
    );

    assign scan_ctl.start = in_xfer;
    assign scan_ctl.valid = rd_valid_reg;
    assign scan_ctl.idx   = rd_idx_reg;

    mre_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (scan_ctl),
        .key     (key_reg),
        .entry   (rd_data),
        .res_reg (scan_res)
    );

    // command decision from the finished scan
    assign rank_sum = scan_res.smaller + CNT_W'(scan_res.found);

    always_comb begin
        upd_en      = 1'b0;
        upd_addr    = scan_res.hit_idx;
        upd_cnt     = scan_res.hit_cnt;
        upd_total   = total_reg;
        status_calc = RES_OK;
        rank_calc   = '0;
        case (cmd_reg)
            CMD_INSERT: begin
                if (total_reg == CNT_MAX) begin
                    status_calc = RES_FULL;
                end else if (scan_res.found) begin
                    if (scan_res.hit_cnt == CNT_MAX) begin
                        status_calc = RES_FULL;
                    end else begin
                        upd_en    = 1'b1;
                        upd_cnt   = scan_res.hit_cnt + CNT_W'(1);
                        upd_total = total_reg + CNT_W'(1);
                    end
                end else if (!scan_res.have_free) begin
                    status_calc = RES_FULL;
                end else begin
                    upd_en    = 1'b1;
                    upd_addr  = scan_res.free_idx;
                    upd_cnt   = CNT_W'(1);
                    upd_total = total_reg + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (!scan_res.found) begin
                    status_calc = RES_ABSENT;
                end else begin
                    upd_en  = 1'b1;
                    upd_cnt = scan_res.hit_cnt - CNT_W'(1);
                    if (total_reg != '0) begin
                        upd_total = total_reg - CNT_W'(1);
                    end
                end
            end
            CMD_RANK: begin
                rank_calc = RANK_W'(rank_sum);
            end
            default: begin
                status_calc = RES_OK;
            end
        endcase
    end

    // table write port: clearing sweep or command write-back
    always_comb begin
        wr = '0;
        case (state_reg)
            ST_CLEAR: begin
                wr.en   = 1'b1;
                wr.addr = idx_reg;
            end
            ST_DONE: begin
                wr.en       = out_free && upd_en;
                wr.addr     = upd_addr;
                wr.data.key = key_reg;
                wr.data.cnt = upd_cnt;
            end
            default: begin
                wr = '0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        total_next    = total_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        rank_next     = rank_reg;
        status_next   = status_reg;
        case (state_reg)
            ST_CLEAR: begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_LAST) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    cmd_next   = s_tuser;
                    key_next   = s_tdata;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                rd_valid_next = 1'b1;
                rd_idx_next   = idx_reg;
                idx_next      = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_LAST) begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    total_next    = upd_total;
                    rank_next     = rank_calc;
                    status_next   = status_calc;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            idx_reg      <= '0;
            cmd_reg      <= '0;
            key_reg      <= '0;
            total_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            rank_reg     <= '0;
            status_reg   <= RES_OK;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cmd_reg      <= cmd_next;
            key_reg      <= key_next;
            total_reg    <= total_next;
            rd_valid_reg <= rd_valid_next;
            rd_idx_reg   <= rd_idx_next;
            m_tvalid_reg <= m_tvalid_next;
            rank_reg     <= rank_next;
            status_reg   <= status_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(rank_reg);
    assign m_tuser  = status_reg;

    // a result only appears after the write-back step
    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result issued outside write-back step");

    // the copy total moves only at write-back
    a_total_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DONE) |=> (total_reg == $past(total_reg)))
        else $error("copy total changed outside write-back");

    // a successful insert adds exactly one copy
    a_insert_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free && cmd_reg == CMD_INSERT
         && status_calc == RES_OK) |=> (total_reg == $past(total_reg) + CNT_W'(1)))
        else $error("insert did not add one copy");

    // a nonzero rank never comes with an error status
    a_rank_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && rank_reg != '0) |-> (status_reg == RES_OK))
        else $error("rank reported with error status");

endmodule

// ===== bench/multiset_rank_engine_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for multiset_rank_engine_core: a shadow multiset predicts
// rank and status for every command and checks each result transfer in order.
// Depends on mre_pkg and the multiset_rank_engine_core RTL.
module multiset_rank_engine_core_tb;
    import mre_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 580;
    localparam int PRESSURE_AFTER = 40;
    localparam int PRESSURE_HOLD  = 4000;
    localparam int IDLE_LIMIT     = 20000;
    localparam int DRAIN_CYCLES   = 1100;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
    } mset_cmd_t;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        logic [STATUS_W-1:0] status;
    } mset_res_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [KEY_W-1:0]      s_tdata  = '0;
    logic [CMD_W-1:0]      s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]   m_tuser;

    multiset_rank_engine_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the multiset
    logic [KEY_W-1:0] shadow_keys   [ENTRIES];
    logic [CNT_W-1:0] shadow_counts [ENTRIES];
    logic [CNT_W-1:0] shadow_total;

    mset_cmd_t   pending_cmds[$];
    mset_res_t   expected_results[$];
    mset_cmd_t   cur_cmd;
    mset_res_t   want;
    logic [KEY_W-1:0] key_pool [24];

    int          error_count   = 0;
    int          checked_count = 0;
    int          cmd_seen [4]  = '{0, 0, 0, 0};
    int unsigned send_gap      = 0;
    int unsigned hold_left     = 0;
    bit          pressure_done = 1'b0;
    int          idle_cycles   = 0;

    // applies one command to the shadow multiset and returns its result
    function automatic mset_res_t apply_command(mset_cmd_t c);
        mset_res_t        r;
        logic             found;
        logic             have_free;
        int unsigned      hit;
        int unsigned      free_slot;
        logic [31:0]      smaller;
        found     = 1'b0;
        have_free = 1'b0;
        hit       = 0;
        free_slot = 0;
        smaller   = '0;
        r.rank    = '0;
        r.status  = RES_OK;
        // one pass: matching entry, lowest free entry, sum of smaller copies
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_counts[i] == '0) begin
                if (!have_free) begin
                    have_free = 1'b1;
                    free_slot = i;
                end
            end else if (shadow_keys[i] == c.key) begin
                found = 1'b1;
                hit   = i;
            end else if ($signed(shadow_keys[i]) < $signed(c.key)) begin
                smaller = smaller + 32'(shadow_counts[i]);
            end
        end
        case (c.cmd)
            CMD_INSERT: begin
                if (shadow_total == CNT_MAX) begin
                    r.status = RES_FULL;
                end else if (found) begin
                    if (shadow_counts[hit] == CNT_MAX) begin
                        r.status = RES_FULL;
                    end else begin
                        shadow_counts[hit] = shadow_counts[hit] + 1'b1;
                        shadow_total       = shadow_total + 1'b1;
                    end
                end else if (!have_free) begin
                    r.status = RES_FULL;
                end else begin
                    shadow_keys[free_slot]   = c.key;
                    shadow_counts[free_slot] = CNT_W'(1);
                    shadow_total             = shadow_total + 1'b1;
                end
            end
            CMD_DELETE: begin
                if (!found) begin
                    r.status = RES_ABSENT;
                end else begin
                    shadow_counts[hit] = shadow_counts[hit] - 1'b1;
                    if (shadow_total != '0)
                        shadow_total = shadow_total - 1'b1;
                end
            end
            CMD_RANK: begin
                r.rank = RANK_W'(smaller + (found ? 32'd1 : 32'd0));
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 4);
        else if (r < 97)
            return $urandom_range(5, 40);
        return $urandom_range(200, 1500);
    endfunction

    function automatic void push_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
        mset_cmd_t c;
        c.cmd = cmd;
        c.key = key;
        pending_cmds.push_back(c);
    endfunction

    // driver: offers queued commands, predicts each accepted transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_command(cur_cmd));
                cmd_seen[cur_cmd.cmd]++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the current item
            end else if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cur_cmd = pending_cmds.pop_front();
                s_tuser  <= cur_cmd.cmd;
                s_tdata  <= cur_cmd.key;
                s_tvalid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!pressure_done && checked_count >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
            hold_left = pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, rank field %h status %0d",
                         $realtime, m_tdata, m_tuser);
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== OUT_DATA_W'(want.rank)) begin
                    error_count++;
                    $display("%0t: rank mismatch, expected %0d actual %0d (tdata %h)",
                             $realtime, want.rank, m_tdata[RANK_W-1:0], m_tdata);
                end
                if (m_tuser !== want.status) begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $realtime, want.status, m_tuser);
                end
            end
            checked_count++;
        end
    end

    // watchdog: ends the run when no transfer happens for too long
    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        int unsigned      r;
        int               total_cmds;

        for (int i = 0; i < ENTRIES; i++) begin
            shadow_keys[i]   = '0;
            shadow_counts[i] = '0;
        end
        shadow_total = '0;

        // directed: empty table, extremes, duplicates, last copy, unused code
        push_cmd(CMD_RANK,   32'h0000_0000);
        push_cmd(CMD_DELETE, 32'h0000_0005);
        push_cmd(CMD_INSERT, 32'h8000_0000);
        push_cmd(CMD_INSERT, 32'h7FFF_FFFF);
        push_cmd(CMD_INSERT, 32'h0000_0000);
        push_cmd(CMD_INSERT, 32'hFFFF_FFFF);
        push_cmd(CMD_INSERT, 32'h0000_0001);
        push_cmd(CMD_INSERT, 32'h0000_0000);
        push_cmd(CMD_RANK,   32'h8000_0000);
        push_cmd(CMD_RANK,   32'h7FFF_FFFF);
        push_cmd(CMD_RANK,   32'h0000_0000);
        push_cmd(CMD_RANK,   32'hFFFF_FFFF);
        push_cmd(CMD_RANK,   32'h0000_0005);
        push_cmd(CMD_RANK,   32'h8000_0001);
        push_cmd(CMD_DELETE, 32'h0000_0000);
        push_cmd(CMD_DELETE, 32'h0000_0000);
        push_cmd(CMD_RANK,   32'h0000_0000);
        push_cmd(CMD_DELETE, 32'h0000_0000);
        push_cmd(CMD_INSERT, 32'h0000_0007);
        push_cmd(CMD_RANK,   32'h7FFF_FFFF);
        push_cmd(CMD_UNUSED, 32'hA5A5_A5A5);
        push_cmd(CMD_UNUSED, 32'h5A5A_5A5A);
        push_cmd(CMD_DELETE, 32'h8000_0000);
        push_cmd(CMD_RANK,   32'h8000_0000);

        // key pool so that deletes and ranks mostly hit stored keys
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = 32'h0000_0001;
        for (int i = 5; i < 24; i++) begin
            if (i < 14)
                key_pool[i] = 32'($signed($urandom_range(0, 40)) - 20);
            else
                key_pool[i] = $urandom;
        end

        // random: mostly pool keys, some arbitrary keys and unused codes
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                cmd = CMD_INSERT;
            else if (r < 65)
                cmd = CMD_DELETE;
            else if (r < 95)
                cmd = CMD_RANK;
            else
                cmd = CMD_UNUSED;
            if ($urandom_range(0, 3) != 0)
                key = key_pool[$urandom_range(0, 23)];
            else
                key = $urandom;
            push_cmd(cmd, key);
        end
        total_cmds = pending_cmds.size();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // wait until every command has produced its checked result
        while (checked_count < total_cmds)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_results.size() != 0 || checked_count != total_cmds) begin
            error_count++;
            $display("%0t: result count off, expected %0d actual %0d",
                     $realtime, total_cmds, checked_count);
        end

        $display("Checked %0d results: %0d inserts, %0d deletes, %0d ranks, %0d unused codes",
                 checked_count, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
        $display("Random back-pressure on both sides, one long receiver hold-off");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
